// ----- hw/rtl/nat_address_rewrite_checksum_fix_assert.svh -----
// ----------------------------------------------------------------------------
// NAT rewrite assertion macros
// Shared property forms for the NAT address rewrite block.
// ----------------------------------------------------------------------------
`ifndef NAT_ADDRESS_REWRITE_CHECKSUM_FIX_ASSERT_SVH
`define NAT_ADDRESS_REWRITE_CHECKSUM_FIX_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define NAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nat rewrite assertion failed");

// Next-cycle implication, disabled while in reset
`define NAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nat rewrite assertion failed");

`endif

// ----- hw/rtl/nat_pkg.sv -----
// ----------------------------------------------------------------------------
// NAT rewrite package
// Types, codes and sizes shared by the NAT address rewrite modules.
// ----------------------------------------------------------------------------
package nat_pkg;

   // Client table size and derived index width
   localparam int NUM_CLIENTS = 64;
   localparam int IDX_W       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

   // Decoupling queue between classifier and executor
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request modes
   localparam logic [1:0] MODE_UP   = 2'd0;
   localparam logic [1:0] MODE_DOWN = 2'd1;
   localparam logic [1:0] MODE_BIND = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_IP_SHORT  = 3'd1;
   localparam logic [2:0] ST_NOT_V4    = 3'd2;
   localparam logic [2:0] ST_L4_SHORT  = 3'd3;
   localparam logic [2:0] ST_NO_CLIENT = 3'd4;
   localparam logic [2:0] ST_BOUND     = 3'd5;

   // Header constants
   localparam logic [15:0] MIN_IP_LEN  = 16'd20;
   localparam logic [3:0]  VERSION_V4  = 4'h4;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [6:0]  TCP_HDR_LEN = 7'd20;
   localparam logic [6:0]  UDP_HDR_LEN = 7'd8;

   // Work kinds decided by the classifier
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_PASS = 2'd0;
   localparam kind_type KIND_BIND = 2'd1;
   localparam kind_type KIND_UP   = 2'd2;
   localparam kind_type KIND_DOWN = 2'd3;

   // Classified request as held in the queue
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  status;
      logic [5:0]  client_index;
      logic [31:0] bind_address;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] ip_checksum;
      logic [15:0] l4_checksum;
      logic        l4_want;
      logic        l4_short;
   } entry_type;

   // Finished result
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] new_source_addr;
      logic [31:0] new_dest_addr;
      logic [15:0] new_ip_checksum;
      logic [15:0] new_l4_checksum;
      logic [5:0]  matched_client;
      logic        l4_adjusted;
   } result_type;

   // Queue status toward both sides
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hw/rtl/nat_ram.sv -----
// ----------------------------------------------------------------------------
// NAT generic RAM
// One write port, one read port, registered read data, old data on collision.
// ----------------------------------------------------------------------------
module nat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/nat_front.sv -----
// ----------------------------------------------------------------------------
// NAT request classifier
// Checks length, version and client range and sorts each request by kind.
// ----------------------------------------------------------------------------
module nat_front (
   input  logic [1:0]         mode,
   input  logic [5:0]         client_index,
   input  logic [31:0]        bind_address,
   input  logic [15:0]        packet_length,
   input  logic [7:0]         version_ihl,
   input  logic [7:0]         protocol,
   input  logic [15:0]        frag_field,
   input  logic [31:0]        source_addr,
   input  logic [31:0]        dest_addr,
   input  logic [15:0]        ip_checksum,
   input  logic [15:0]        l4_checksum,
   output nat_pkg::entry_type entry
);

   logic       cli_ok;
   logic       is_tcp;
   logic       is_udp;
   logic [6:0] l4_need;

   // Transport checks
   assign cli_ok  = 32'(client_index) < 32'(nat_pkg::NUM_CLIENTS);
   assign is_tcp  = protocol == nat_pkg::PROTO_TCP;
   assign is_udp  = protocol == nat_pkg::PROTO_UDP;
   assign l4_need = {1'b0, version_ihl[3:0], 2'b00}
                  + (is_tcp ? nat_pkg::TCP_HDR_LEN : nat_pkg::UDP_HDR_LEN);

   // Sort the request
   always_comb begin
      entry.kind         = nat_pkg::KIND_PASS;
      entry.status       = nat_pkg::ST_OK;
      entry.client_index = client_index;
      entry.bind_address = bind_address;
      entry.source_addr  = source_addr;
      entry.dest_addr    = dest_addr;
      entry.ip_checksum  = ip_checksum;
      entry.l4_checksum  = l4_checksum;
      entry.l4_want      = (frag_field[12:0] == 13'd0) && (is_tcp || is_udp);
      entry.l4_short     = packet_length < {9'd0, l4_need};
      case (mode)
         nat_pkg::MODE_BIND: begin
            if (cli_ok) begin
               entry.kind = nat_pkg::KIND_BIND;
            end else begin
               entry.status = nat_pkg::ST_NO_CLIENT;
            end
         end
         nat_pkg::MODE_UP, nat_pkg::MODE_DOWN: begin
            if (packet_length < nat_pkg::MIN_IP_LEN) begin
               entry.status = nat_pkg::ST_IP_SHORT;
            end else if (version_ihl[7:4] != nat_pkg::VERSION_V4) begin
               entry.status = nat_pkg::ST_NOT_V4;
            end else if (mode == nat_pkg::MODE_DOWN) begin
               entry.kind = nat_pkg::KIND_DOWN;
            end else if (cli_ok) begin
               entry.kind = nat_pkg::KIND_UP;
            end else begin
               entry.status = nat_pkg::ST_NO_CLIENT;
            end
         end
         default: begin
            // unused mode code passes the header through
            entry.kind = nat_pkg::KIND_PASS;
         end
      endcase
   end

endmodule

// ----- hw/rtl/nat_queue.sv -----
// ----------------------------------------------------------------------------
// NAT request queue
// Short FIFO of classified requests between classifier and executor.
// ----------------------------------------------------------------------------
module nat_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nat_pkg::entry_type        push_entry,
   input  logic                      pop,
   output nat_pkg::entry_type        head,
   output nat_pkg::queue_status_type status
);

   nat_pkg::entry_type         mem_ff [nat_pkg::QUEUE_DEPTH];
   logic [nat_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nat_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nat_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   localparam logic [nat_pkg::QPTR_W-1:0] PTR_LAST = nat_pkg::QPTR_W'(nat_pkg::QUEUE_DEPTH - 1);
   localparam logic [nat_pkg::QCNT_W-1:0] CNT_FULL = nat_pkg::QCNT_W'(nat_pkg::QUEUE_DEPTH);

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CNT_FULL;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/nat_back.sv -----
// ----------------------------------------------------------------------------
// NAT rewrite executor
// Binds clients, rewrites addresses, scans the bound table and adjusts
// the IP and transport checksums incrementally.
// ----------------------------------------------------------------------------
module nat_back (
   input  logic                      clock,
   input  logic                      reset,
   input  nat_pkg::entry_type        head,
   input  nat_pkg::queue_status_type q_status,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output nat_pkg::result_type       result,
   output logic                      result_empty
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_WAIT = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_DN_WAIT = 3'd3;
   localparam logic [2:0] S_DELTA   = 3'd4;
   localparam logic [2:0] S_ADJ1    = 3'd5;
   localparam logic [2:0] S_ADJ2    = 3'd6;

   localparam logic [nat_pkg::IDX_W-1:0] IDX_LAST = nat_pkg::IDX_W'(nat_pkg::NUM_CLIENTS - 1);

   logic [2:0]                  state_ff, state_in;
   nat_pkg::entry_type          cur_ff, cur_in;
   logic [31:0]                 nsrc_ff, nsrc_in;
   logic [31:0]                 ndst_ff, ndst_in;
   logic [nat_pkg::IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [nat_pkg::IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [nat_pkg::IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic                        scan_done_ff, scan_done_in;
   logic signed [17:0]          delta_ff, delta_in;
   logic [17:0]                 ip_abs_ff, ip_abs_in;
   logic                        ip_neg_ff, ip_neg_in;
   logic [17:0]                 l4_abs_ff, l4_abs_in;
   logic                        l4_neg_ff, l4_neg_in;
   logic [nat_pkg::NUM_CLIENTS-1:0] bound_valid_ff, bound_valid_in;
   logic [nat_pkg::NUM_CLIENTS-1:0] learned_valid_ff, learned_valid_in;
   nat_pkg::result_type         res_ff, res_in;
   logic                        res_vld_ff, res_vld_in;

   logic                        b_we;
   logic [nat_pkg::IDX_W-1:0]   b_raddr;
   logic [31:0]                 b_rdata;
   logic                        l_we;
   logic [nat_pkg::IDX_W-1:0]   l_raddr;
   logic [31:0]                 l_rdata;
   logic [nat_pkg::IDX_W-1:0]   head_idx;
   logic [31:0]                 old_addr;
   logic [31:0]                 new_addr;
   logic signed [18:0]          ip_sum;
   logic signed [18:0]          l4_sum;
   logic [15:0]                 ip_fold;
   logic [15:0]                 l4_fold;
   logic                        l4_do;

   // Sum of the two 16-bit halves of an address
   function automatic logic [16:0] half_sum(input logic [31:0] v);
      return {1'b0, v[15:0]} + {1'b0, v[31:16]};
   endfunction

   // Fold a magnitude to 16 bits in ones' complement, invert when negative
   function automatic logic [15:0] cks_fold(input logic [17:0] a, input logic neg);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = {15'd0, a[17:16]} + {1'b0, a[15:0]};
      f2 = f1[15:0] + {15'd0, f1[16]};
      return neg ? ~f2 : f2;
   endfunction

   // Result that carries the header unchanged
   function automatic nat_pkg::result_type pass_result(input nat_pkg::entry_type e,
                                                       input logic [2:0] st);
      nat_pkg::result_type r;
      r.status          = st;
      r.new_source_addr = e.source_addr;
      r.new_dest_addr   = e.dest_addr;
      r.new_ip_checksum = e.ip_checksum;
      r.new_l4_checksum = e.l4_checksum;
      r.matched_client  = 6'd0;
      r.l4_adjusted     = 1'b0;
      return r;
   endfunction

   // Client tables
   nat_ram #(.WIDTH(32), .DEPTH(nat_pkg::NUM_CLIENTS)) u_bound_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (head_idx),
      .wr_data (head.bind_address),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   nat_ram #(.WIDTH(32), .DEPTH(nat_pkg::NUM_CLIENTS)) u_learned_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (head_idx),
      .wr_data (head.source_addr),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   assign head_idx     = nat_pkg::IDX_W'(head.client_index);
   assign result       = res_ff;
   assign result_empty = !res_vld_ff;

   // Checksum arithmetic pieces
   assign old_addr = (cur_ff.kind == nat_pkg::KIND_UP) ? cur_ff.source_addr : cur_ff.dest_addr;
   assign new_addr = (cur_ff.kind == nat_pkg::KIND_UP) ? nsrc_ff : ndst_ff;
   assign ip_sum   = {delta_ff[17], delta_ff} + $signed({3'b000, cur_ff.ip_checksum});
   assign l4_sum   = {delta_ff[17], delta_ff} + $signed({3'b000, cur_ff.l4_checksum});
   assign ip_fold  = cks_fold(ip_abs_ff, ip_neg_ff);
   assign l4_fold  = cks_fold(l4_abs_ff, l4_neg_ff);
   assign l4_do    = cur_ff.l4_want && !cur_ff.l4_short;

   // Sequence one request at a time
   always_comb begin
      state_in         = state_ff;
      cur_in           = cur_ff;
      nsrc_in          = nsrc_ff;
      ndst_in          = ndst_ff;
      match_idx_in     = match_idx_ff;
      scan_idx_in      = scan_idx_ff;
      cmp_idx_in       = cmp_idx_ff;
      cmp_vld_in       = cmp_vld_ff;
      scan_done_in     = scan_done_ff;
      delta_in         = delta_ff;
      ip_abs_in        = ip_abs_ff;
      ip_neg_in        = ip_neg_ff;
      l4_abs_in        = l4_abs_ff;
      l4_neg_in        = l4_neg_ff;
      bound_valid_in   = bound_valid_ff;
      learned_valid_in = learned_valid_ff;
      res_in           = res_ff;
      res_vld_in       = res_vld_ff;
      q_pop            = 1'b0;
      b_we             = 1'b0;
      b_raddr          = scan_idx_ff;
      l_we             = 1'b0;
      l_raddr          = cmp_idx_ff;

      // drop the result once taken
      if (rsp_pop && res_vld_ff) begin
         res_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty && !res_vld_ff) begin
               q_pop        = 1'b1;
               cur_in       = head;
               nsrc_in      = head.source_addr;
               ndst_in      = head.dest_addr;
               match_idx_in = '0;
               scan_idx_in  = '0;
               cmp_vld_in   = 1'b0;
               scan_done_in = 1'b0;
               case (head.kind)
                  nat_pkg::KIND_BIND: begin
                     b_we                     = 1'b1;
                     bound_valid_in[head_idx] = 1'b1;
                     res_in                   = pass_result(head, nat_pkg::ST_BOUND);
                     res_vld_in               = 1'b1;
                  end
                  nat_pkg::KIND_UP: begin
                     b_raddr                    = head_idx;
                     l_we                       = 1'b1;
                     learned_valid_in[head_idx] = 1'b1;
                     state_in                   = S_UP_WAIT;
                  end
                  nat_pkg::KIND_DOWN: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in     = pass_result(head, head.status);
                     res_vld_in = 1'b1;
                  end
               endcase
            end
         end
         S_UP_WAIT: begin
            nsrc_in  = b_rdata;
            state_in = S_DELTA;
         end
         S_SCAN: begin
            // issue one table read per cycle, compare the previous one
            b_raddr    = scan_idx_ff;
            cmp_vld_in = !scan_done_ff;
            cmp_idx_in = scan_idx_ff;
            if (scan_idx_ff == IDX_LAST) begin
               scan_done_in = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (cmp_vld_ff && bound_valid_ff[cmp_idx_ff] && (b_rdata == cur_ff.dest_addr)) begin
               match_idx_in = cmp_idx_ff;
               l_raddr      = cmp_idx_ff;
               state_in     = S_DN_WAIT;
            end else if (cmp_vld_ff && (cmp_idx_ff == IDX_LAST)) begin
               res_in     = pass_result(cur_ff, nat_pkg::ST_NO_CLIENT);
               res_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DN_WAIT: begin
            // a client never learned reads as zero
            ndst_in  = learned_valid_ff[match_idx_ff] ? l_rdata : 32'd0;
            state_in = S_DELTA;
         end
         S_DELTA: begin
            delta_in = $signed({1'b0, half_sum(old_addr)}) - $signed({1'b0, half_sum(new_addr)});
            state_in = S_ADJ1;
         end
         S_ADJ1: begin
            ip_neg_in = ip_sum[18];
            ip_abs_in = ip_sum[18] ? 18'(-ip_sum) : ip_sum[17:0];
            l4_neg_in = l4_sum[18];
            l4_abs_in = l4_sum[18] ? 18'(-l4_sum) : l4_sum[17:0];
            state_in  = S_ADJ2;
         end
         S_ADJ2: begin
            res_in.status          = (cur_ff.l4_want && cur_ff.l4_short) ?
                                     nat_pkg::ST_L4_SHORT : nat_pkg::ST_OK;
            res_in.new_source_addr = nsrc_ff;
            res_in.new_dest_addr   = ndst_ff;
            res_in.new_ip_checksum = ip_fold;
            res_in.new_l4_checksum = l4_do ? l4_fold : cur_ff.l4_checksum;
            res_in.matched_client  = (cur_ff.kind == nat_pkg::KIND_DOWN) ?
                                     6'(match_idx_ff) : 6'd0;
            res_in.l4_adjusted     = l4_do;
            res_vld_in             = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         bound_valid_ff   <= '0;
         learned_valid_ff <= '0;
         res_vld_ff       <= 1'b0;
         cmp_vld_ff       <= 1'b0;
         scan_done_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         bound_valid_ff   <= bound_valid_in;
         learned_valid_ff <= learned_valid_in;
         res_vld_ff       <= res_vld_in;
         cmp_vld_ff       <= cmp_vld_in;
         scan_done_ff     <= scan_done_in;
      end
   end

   // Working data
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      nsrc_ff      <= nsrc_in;
      ndst_ff      <= ndst_in;
      match_idx_ff <= match_idx_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      delta_ff     <= delta_in;
      ip_abs_ff    <= ip_abs_in;
      ip_neg_ff    <= ip_neg_in;
      l4_abs_ff    <= l4_abs_in;
      l4_neg_ff    <= l4_neg_in;
      res_ff       <= res_in;
   end

endmodule

// ----- hw/rtl/nat_address_rewrite_checksum_fix.sv -----
// Bind, pass-through and error requests are answered straight from idle; upstream
// runs through UP_WAIT, DELTA, ADJ1 and ADJ2; downstream scans the bound table,
// answers a miss from the scan, else runs through DN_WAIT, DELTA, ADJ1 and ADJ2.
// One request is handled at a time, the next starts the cycle after the result is
// taken; a 2-entry queue takes requests meanwhile. Synchronous reset empties queue
// and result and clears the valid bits; unlearned addresses read as zero, no clearing.
// ----------------------------------------------------------------------------
// NAT address rewrite with checksum fix
// Rewrites IPv4 source or destination addresses per bound client and
// updates the IP and transport checksums incrementally.
// ----------------------------------------------------------------------------
`include "nat_address_rewrite_checksum_fix_assert.svh"

module nat_address_rewrite_checksum_fix (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_client_index,
   input  logic [31:0] req_bind_address,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_version_ihl,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_frag_field,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_dest_addr,
   input  logic [15:0] req_ip_checksum,
   input  logic [15:0] req_l4_checksum,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_new_source_addr,
   output logic [31:0] rsp_new_dest_addr,
   output logic [15:0] rsp_new_ip_checksum,
   output logic [15:0] rsp_new_l4_checksum,
   output logic [5:0]  rsp_matched_client,
   output logic        rsp_l4_adjusted
);

   nat_pkg::entry_type        req_entry;
   nat_pkg::entry_type        q_head;
   nat_pkg::queue_status_type q_status;
   nat_pkg::result_type       rsp_result;
   logic                      q_push;
   logic                      q_pop;
   logic                      rsp_ok;
   logic                      rsp_ok_or_short;

   // Classify the incoming request
   nat_front u_front (
      .mode          (req_mode),
      .client_index  (req_client_index),
      .bind_address  (req_bind_address),
      .packet_length (req_packet_length),
      .version_ihl   (req_version_ihl),
      .protocol      (req_protocol),
      .frag_field    (req_frag_field),
      .source_addr   (req_source_addr),
      .dest_addr     (req_dest_addr),
      .ip_checksum   (req_ip_checksum),
      .l4_checksum   (req_l4_checksum),
      .entry         (req_entry)
   );

   assign q_push   = req_push && !q_status.full;
   assign req_full = q_status.full;

   // Hold classified requests
   nat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (req_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // Carry out requests
   nat_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .result       (rsp_result),
      .result_empty (rsp_empty)
   );

   assign rsp_status          = rsp_result.status;
   assign rsp_new_source_addr = rsp_result.new_source_addr;
   assign rsp_new_dest_addr   = rsp_result.new_dest_addr;
   assign rsp_new_ip_checksum = rsp_result.new_ip_checksum;
   assign rsp_new_l4_checksum = rsp_result.new_l4_checksum;
   assign rsp_matched_client  = rsp_result.matched_client;
   assign rsp_l4_adjusted     = rsp_result.l4_adjusted;

   // Checks
   assign rsp_ok          = rsp_status == nat_pkg::ST_OK;
   assign rsp_ok_or_short = rsp_ok || (rsp_status == nat_pkg::ST_L4_SHORT);

   `NAT_ASSERT_IMPL(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   `NAT_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_status.empty)
   `NAT_ASSERT_IMPL(a_adj_ok, clock, reset, !rsp_empty && rsp_l4_adjusted, rsp_ok)
   `NAT_ASSERT_IMPL(a_match_ok, clock, reset, !rsp_empty && (|rsp_matched_client), rsp_ok_or_short)

endmodule

// ----- tb/sv/tb_nat_address_rewrite_checksum_fix.sv -----
// ----------------------------------------------------------------------------
// NAT address rewrite testbench
// Drives IPv4 header requests (bind, upstream, downstream, spare mode) into the
// rewrite block through its push/full queue, predicts results with an in-bench
// copy of the client table and checksum arithmetic (typed rows give their own),
// compares each popped result field by field. A directed list comes first, then
// random traffic built mostly from bound clients and pooled tunnel addresses.
// ----------------------------------------------------------------------------
module tb_nat_address_rewrite_checksum_fix;

   // Mode code the package leaves unnamed: header passes through untouched
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam bit         BY_MODEL     = 1'b0;
   localparam bit         TYPED        = 1'b1;
   localparam int         RANDOM_ITEMS = 850;
   localparam int         POOL_SIZE    = 8;
   localparam int         HOLD_START   = 2000;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  client_index;
      logic [31:0] bind_address;
      logic [15:0] packet_length;
      logic [7:0]  version_ihl;
      logic [7:0]  protocol;
      logic [15:0] frag_field;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] ip_checksum;
      logic [15:0] l4_checksum;
   } header_request_type;

   typedef struct packed {
      header_request_type hdr;
      logic               typed;
      logic [2:0]         status;
   } directed_row_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_push   = 1'b0;
   header_request_type drv_req    = '0;
   logic               drv_typed  = 1'b0;
   logic [2:0]         drv_status = nat_pkg::ST_OK;
   logic               rsp_pop    = 1'b0;

   logic        req_full;
   logic        rsp_empty;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_new_source_addr;
   logic [31:0] rsp_new_dest_addr;
   logic [15:0] rsp_new_ip_checksum;
   logic [15:0] rsp_new_l4_checksum;
   logic [5:0]  rsp_matched_client;
   logic        rsp_l4_adjusted;

   // Client table as the block should hold it
   logic [31:0] tunnel_addr  [nat_pkg::NUM_CLIENTS];
   logic        tunnel_valid [nat_pkg::NUM_CLIENTS];
   logic [31:0] learned_addr [nat_pkg::NUM_CLIENTS];

   nat_pkg::result_type pending_results [$];
   directed_row_type    directed_rows [$];
   logic [31:0]         tunnel_pool [POOL_SIZE];
   int unsigned         fault_count = 0;

   nat_address_rewrite_checksum_fix DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_mode            (drv_req.mode),
      .req_client_index    (drv_req.client_index),
      .req_bind_address    (drv_req.bind_address),
      .req_packet_length   (drv_req.packet_length),
      .req_version_ihl     (drv_req.version_ihl),
      .req_protocol        (drv_req.protocol),
      .req_frag_field      (drv_req.frag_field),
      .req_source_addr     (drv_req.source_addr),
      .req_dest_addr       (drv_req.dest_addr),
      .req_ip_checksum     (drv_req.ip_checksum),
      .req_l4_checksum     (drv_req.l4_checksum),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_status          (rsp_status),
      .rsp_new_source_addr (rsp_new_source_addr),
      .rsp_new_dest_addr   (rsp_new_dest_addr),
      .rsp_new_ip_checksum (rsp_new_ip_checksum),
      .rsp_new_l4_checksum (rsp_new_l4_checksum),
      .rsp_matched_client  (rsp_matched_client),
      .rsp_l4_adjusted     (rsp_l4_adjusted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ones' complement add of a signed delta into a 16-bit checksum
   function automatic logic [15:0] fold_checksum(int delta, logic [15:0] cks);
      int sum;
      bit neg;
      sum = delta + int'({16'h0, cks});
      neg = sum < 0;
      if (neg) sum = -sum;
      sum = (sum >> 16) + (sum & 32'hffff);
      sum = sum + (sum >> 16);
      return neg ? ~sum[15:0] : sum[15:0];
   endfunction

   function automatic int half_word_sum(logic [31:0] addr);
      return int'({16'h0, addr[15:0]}) + int'({16'h0, addr[31:16]});
   endfunction

   function automatic nat_pkg::result_type unchanged_result(header_request_type r,
                                                            logic [2:0] status);
      nat_pkg::result_type res;
      res.status          = status;
      res.new_source_addr = r.source_addr;
      res.new_dest_addr   = r.dest_addr;
      res.new_ip_checksum = r.ip_checksum;
      res.new_l4_checksum = r.l4_checksum;
      res.matched_client  = '0;
      res.l4_adjusted     = 1'b0;
      return res;
   endfunction

   // Predict one result and advance the client table
   function automatic nat_pkg::result_type rewrite_header(header_request_type r);
      nat_pkg::result_type res;
      int delta;
      int need;
      bit hit;
      res   = unchanged_result(r, nat_pkg::ST_OK);
      delta = 0;
      hit   = 1'b0;
      if (r.mode == nat_pkg::MODE_BIND) begin
         if (int'(r.client_index) < nat_pkg::NUM_CLIENTS) begin
            tunnel_addr[r.client_index]  = r.bind_address;
            tunnel_valid[r.client_index] = 1'b1;
            res.status = nat_pkg::ST_BOUND;
         end else begin
            res.status = nat_pkg::ST_NO_CLIENT;
         end
      end else if (r.mode == MODE_SPARE) begin
         res.status = nat_pkg::ST_OK;
      end else if (r.packet_length < nat_pkg::MIN_IP_LEN) begin
         res.status = nat_pkg::ST_IP_SHORT;
      end else if (r.version_ihl[7:4] != nat_pkg::VERSION_V4) begin
         res.status = nat_pkg::ST_NOT_V4;
      end else begin
         if (r.mode == nat_pkg::MODE_UP) begin
            if (int'(r.client_index) < nat_pkg::NUM_CLIENTS) begin
               learned_addr[r.client_index] = r.source_addr;
               res.new_source_addr = tunnel_addr[r.client_index];
               delta = half_word_sum(r.source_addr) - half_word_sum(res.new_source_addr);
               hit = 1'b1;
            end else begin
               res.status = nat_pkg::ST_NO_CLIENT;
            end
         end else begin
            // Lowest matching client wins
            for (int i = 0; i < nat_pkg::NUM_CLIENTS; i++) begin
               if (!hit && tunnel_valid[i] && tunnel_addr[i] == r.dest_addr) begin
                  hit = 1'b1;
                  res.matched_client = 6'(i);
                  res.new_dest_addr  = learned_addr[i];
                  delta = half_word_sum(r.dest_addr) - half_word_sum(res.new_dest_addr);
               end
            end
            if (!hit) res.status = nat_pkg::ST_NO_CLIENT;
         end
         if (hit) begin
            res.new_ip_checksum = fold_checksum(delta, r.ip_checksum);
            if (r.frag_field[12:0] == 13'd0 &&
                (r.protocol == nat_pkg::PROTO_TCP || r.protocol == nat_pkg::PROTO_UDP)) begin
               need = int'(r.version_ihl[3:0]) * 4 +
                      ((r.protocol == nat_pkg::PROTO_TCP) ? int'(nat_pkg::TCP_HDR_LEN) :
                                                            int'(nat_pkg::UDP_HDR_LEN));
               if (int'(r.packet_length) < need) begin
                  res.status = nat_pkg::ST_L4_SHORT;
               end else begin
                  res.new_l4_checksum = fold_checksum(delta, r.l4_checksum);
                  res.l4_adjusted     = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   // One line of the directed list
   task automatic add_row(input logic [1:0] mode, input logic [5:0] client,
                          input logic [31:0] bind_addr, input logic [15:0] plen,
                          input logic [7:0] vihl, input logic [7:0] proto,
                          input logic [15:0] frag, input logic [31:0] src,
                          input logic [31:0] dst, input logic [15:0] ipc,
                          input logic [15:0] l4c, input bit typed,
                          input logic [2:0] status);
      directed_row_type row;
      row.hdr = '{mode, client, bind_addr, plen, vihl, proto, frag, src, dst, ipc, l4c};
      row.typed  = typed;
      row.status = status;
      directed_rows.push_back(row);
   endtask

   // Random header: mostly well-formed traffic around pooled tunnel addresses
   function automatic header_request_type random_request();
      header_request_type r;
      int pick;
      int need;
      r.bind_address  = $urandom;
      r.source_addr   = $urandom;
      r.dest_addr     = $urandom;
      r.ip_checksum   = 16'($urandom);
      r.l4_checksum   = 16'($urandom);
      r.client_index  = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 9);
      r.version_ihl = (pick == 0) ? 8'($urandom) :
                      (pick < 3)  ? {nat_pkg::VERSION_V4, 4'($urandom)} :
                                    {nat_pkg::VERSION_V4, 4'd5};
      pick = $urandom_range(0, 9);
      r.protocol = (pick < 4) ? nat_pkg::PROTO_TCP :
                   (pick < 7) ? nat_pkg::PROTO_UDP : 8'($urandom);
      r.frag_field = ($urandom_range(0, 9) < 7) ? {3'($urandom), 13'd0} : 16'($urandom);
      need = int'(r.version_ihl[3:0]) * 4 + ((r.protocol == nat_pkg::PROTO_TCP) ? 20 : 8);
      case ($urandom_range(0, 9))
         0: r.packet_length = 16'($urandom_range(0, 19));
         1: r.packet_length = 16'($urandom);
         2, 3: r.packet_length = 16'(need - 1 + $urandom_range(0, 1));
         default: r.packet_length = 16'($urandom_range(20, 1500));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         r.mode = nat_pkg::MODE_BIND;
         if ($urandom_range(0, 9) < 7) r.client_index = 6'($urandom_range(0, 15));
         if ($urandom_range(0, 4) != 0)
            r.bind_address = tunnel_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 47) begin
         r.mode = nat_pkg::MODE_UP;
      end else if (pick < 87) begin
         r.mode = nat_pkg::MODE_DOWN;
         if ($urandom_range(0, 3) != 0)
            r.dest_addr = tunnel_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 92) begin
         r.mode = MODE_SPARE;
      end else begin
         // Broken header: short buffer or odd first byte
         r.mode          = 2'($urandom_range(0, 1));
         r.packet_length = 16'($urandom_range(0, 25));
         r.version_ihl   = 8'($urandom);
      end
      // Upstream that gets past the header checks must use a bound client
      if (r.mode == nat_pkg::MODE_UP && r.packet_length >= nat_pkg::MIN_IP_LEN &&
          r.version_ihl[7:4] == nat_pkg::VERSION_V4) begin
         while (!tunnel_valid[r.client_index]) r.client_index = 6'($urandom_range(0, 63));
      end
      return r;
   endfunction

   // Present one request from this falling edge until it is taken
   task automatic issue_request(input header_request_type r, input bit typed,
                                input logic [2:0] status);
      req_push   <= 1'b1;
      drv_req    <= r;
      drv_typed  <= typed;
      drv_status <= status;
      do @(posedge clock); while (!(req_push && !req_full));
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles != 0) begin
         req_push <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t ERROR %s: expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Record expectations on accept, check results on pop
   always @(posedge clock) begin : scoreboard
      nat_pkg::result_type want;
      if (!reset) begin
         if (req_push && !req_full) begin
            want = rewrite_header(drv_req);
            if (drv_typed) want = unchanged_result(drv_req, drv_status);
            pending_results.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               fault_count++;
               $display("%0t ERROR result: expected none, got status %h", $time, rsp_status);
            end else begin
               want = pending_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("new_source_addr", want.new_source_addr, rsp_new_source_addr);
               compare_field("new_dest_addr", want.new_dest_addr, rsp_new_dest_addr);
               compare_field("new_ip_checksum", 32'(want.new_ip_checksum),
                             32'(rsp_new_ip_checksum));
               compare_field("new_l4_checksum", 32'(want.new_l4_checksum),
                             32'(rsp_new_l4_checksum));
               compare_field("matched_client", 32'(want.matched_client),
                             32'(rsp_matched_client));
               compare_field("l4_adjusted", 32'(want.l4_adjusted), 32'(rsp_l4_adjusted));
            end
         end
      end
   end

   // Result side: changing stall styles plus one long hold to back up the queue
   initial begin : receiver
      int unsigned rx_cycle;
      int unsigned hold_left;
      int unsigned style;
      rx_cycle  = 0;
      hold_left = 0;
      style     = 0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
         if (rx_cycle % 200 == 0) style = $urandom_range(0, 3);
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (style)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= (rx_cycle % 5 == 0);
               default: rsp_pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("nat_address_rewrite_checksum_fix: mismatch");
      $finish;
   end

   initial begin : stimulus
      int burst_left;
      int gap;
      burst_left = 0;
      gap        = 0;
      for (int i = 0; i < nat_pkg::NUM_CLIENTS; i++) begin
         tunnel_addr[i]  = '0;
         tunnel_valid[i] = 1'b0;
         learned_addr[i] = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) tunnel_pool[i] = $urandom;

      // Bindings, header errors, spare mode, checksum and length edges, lookups
      add_row(nat_pkg::MODE_BIND, 6'd0, 32'hC0A8_0001, 16'd40, 8'h45, nat_pkg::PROTO_TCP,
              16'h0, 32'h1111_1111, 32'h2222_2222, 16'h1234, 16'h5678, TYPED,
              nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_BIND, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, TYPED, nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_BIND, 6'd5, 32'h0000_0000, 16'd0, 8'h00, 8'h00, 16'h0,
              32'h0, 32'h0, 16'h0, 16'h0, TYPED, nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_BIND, 6'd7, 32'hC0A8_0001, 16'd60, 8'h45, nat_pkg::PROTO_UDP,
              16'h0, 32'h0A0B_0C0D, 32'h0, 16'hAAAA, 16'h5555, TYPED, nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_BIND, 6'd9, 32'h0A00_0001, 16'd60, 8'h45, nat_pkg::PROTO_UDP,
              16'h0, 32'h0, 32'h0, 16'h0, 16'h0, TYPED, nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_UP, 6'd0, 32'h0, 16'd19, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'h0102_0304, 32'h0506_0708, 16'h1111, 16'h2222, TYPED,
              nat_pkg::ST_IP_SHORT);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd0, 8'h45, nat_pkg::PROTO_UDP, 16'h0,
              32'h0102_0304, 32'hC0A8_0001, 16'h3333, 16'h4444, TYPED,
              nat_pkg::ST_IP_SHORT);
      add_row(nat_pkg::MODE_UP, 6'd0, 32'h0, 16'd60, 8'h65, nat_pkg::PROTO_TCP, 16'h0,
              32'h0102_0304, 32'h0506_0708, 16'h5555, 16'h6666, TYPED,
              nat_pkg::ST_NOT_V4);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'hFFFF, 8'hFF, nat_pkg::PROTO_TCP, 16'h0,
              32'h0102_0304, 32'hC0A8_0001, 16'h7777, 16'h8888, TYPED,
              nat_pkg::ST_NOT_V4);
      add_row(MODE_SPARE, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'hFFFF_FFFF, 32'hC0A8_0001, 16'hFFFF, 16'hFFFF, TYPED, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd0, 32'h0, 16'd40, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'h0102_0304, 32'h0808_0808, 16'hFFFF, 16'h0000, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd63, 32'h0, 16'hFFFF, 8'h45, nat_pkg::PROTO_UDP, 16'h4000,
              32'hFFFF_FFFF, 32'h0808_0404, 16'h0000, 16'hFFFF, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd5, 32'h0, 16'd39, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'hAC10_0005, 32'h0808_0808, 16'hB1C2, 16'hD3E4, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd5, 32'h0, 16'd28, 8'h45, nat_pkg::PROTO_UDP, 16'h0,
              32'hAC10_0006, 32'h0808_0808, 16'h0001, 16'h8000, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd7, 32'h0, 16'd27, 8'h45, nat_pkg::PROTO_UDP, 16'h0,
              32'hAC10_0007, 32'h0101_0101, 16'h4321, 16'h8765, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd63, 32'h0, 16'd100, 8'h45, nat_pkg::PROTO_TCP, 16'h1FFF,
              32'h0000_0000, 32'h0101_0101, 16'h0F0F, 16'hF0F0, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd0, 32'h0, 16'd100, 8'h45, 8'd1, 16'h0,
              32'h7F00_0001, 32'h0101_0101, 16'hABCD, 16'h0123, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd63, 32'h0, 16'd79, 8'h4F, nat_pkg::PROTO_TCP, 16'h0,
              32'h0A0A_0001, 32'h0101_0101, 16'h1357, 16'h2468, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd63, 32'h0, 16'd80, 8'h4F, nat_pkg::PROTO_TCP, 16'h0,
              32'h0A0A_0002, 32'h0101_0101, 16'h1357, 16'h2468, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_UP, 6'd0, 32'h0, 16'd20, 8'h40, nat_pkg::PROTO_TCP, 16'h0,
              32'h0A0A_0003, 32'h0101_0101, 16'h9999, 16'h0000, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd60, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'h0808_0808, 32'hC0A8_0001, 16'hFFFF, 16'h0000, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd60, 8'h45, nat_pkg::PROTO_UDP, 16'h0,
              32'h0808_0808, 32'h0A00_0001, 16'h0000, 16'hFFFF, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd40, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'h0808_0808, 32'hFFFF_FFFF, 16'h1000, 16'h2000, BY_MODEL, nat_pkg::ST_OK);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd60, 8'h45, nat_pkg::PROTO_TCP, 16'h0,
              32'h0808_0808, 32'h1234_5678, 16'h4242, 16'h2424, TYPED,
              nat_pkg::ST_NO_CLIENT);
      add_row(nat_pkg::MODE_BIND, 6'd0, 32'h0A0A_0A0A, 16'd60, 8'h45, nat_pkg::PROTO_TCP,
              16'h0, 32'h0, 32'h0, 16'h0, 16'h0, TYPED, nat_pkg::ST_BOUND);
      add_row(nat_pkg::MODE_DOWN, 6'd0, 32'h0, 16'd60, 8'h45, nat_pkg::PROTO_UDP, 16'h0,
              32'h0808_0808, 32'hC0A8_0001, 16'h5A5A, 16'hA5A5, BY_MODEL, nat_pkg::ST_OK);

      // Hold reset, then release on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed list
      foreach (directed_rows[k]) begin
         pause_sender($urandom_range(0, 2));
         issue_request(directed_rows[k].hdr, directed_rows[k].typed, directed_rows[k].status);
      end

      // Random traffic in bursts
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            pause_sender(gap);
         end
         burst_left--;
         issue_request(random_request(), BY_MODEL, nat_pkg::ST_OK);
      end
      req_push <= 1'b0;

      // Drain, then allow the longest lookup to finish
      while (pending_results.size() != 0) @(posedge clock);
      repeat (nat_pkg::NUM_CLIENTS + 16) @(posedge clock);
      if (fault_count == 0) begin
         $display("nat_address_rewrite_checksum_fix: match");
      end else begin
         $display("nat_address_rewrite_checksum_fix: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/nat_pkg.sv
hw/rtl/nat_ram.sv
hw/rtl/nat_front.sv
hw/rtl/nat_queue.sv
hw/rtl/nat_back.sv
hw/rtl/nat_address_rewrite_checksum_fix.sv
tb/sv/tb_nat_address_rewrite_checksum_fix.sv
